// ----- hw/rtl/hlt_pkg.sv -----
`default_nettype none

package hlt_pkg;

  // Number of tracked node slots and the index width of the per-slot store.
  localparam int unsigned NODE_COUNT = 64;
  localparam int unsigned IDX_W      = $clog2(NODE_COUNT);

  // Field widths fixed by the record format.
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned MAGIC_W  = 32;
  localparam int unsigned NODE_W   = 32;
  localparam int unsigned STATUS_W = 8;
  localparam int unsigned SEQ_W    = 64;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned MISS_W   = 8;
  localparam int unsigned MAP_W    = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [TIME_W-1:0] NS_PER_MS       = 64'd1000000;
  localparam logic [TIME_W-1:0] TIMEOUT_RST     = 64'd5000 * NS_PER_MS;
  localparam logic [STATUS_W-1:0] ONLINE_RST    = 8'd1;
  localparam logic [MISS_W-1:0] MISS_LIMIT_RST  = 8'd3;
  localparam logic [MISS_W-1:0] MISS_MAX        = 8'hFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC      = 3'd0,
    CFG_ONLINE     = 3'd1,
    CFG_SELF       = 3'd2,
    CFG_TIMEOUT    = 3'd3,
    CFG_MISS_LIMIT = 3'd4
  } cfg_idx_e;

  // One slot of the tracker store.
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] chg_time;
    logic [MISS_W-1:0] miss;
  } entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/heartbeat_liveness_tracker_unit.sv -----
// Heartbeat liveness tracker.
// Each input transaction carries one heartbeat record read from a node slot.
// The block checks the record, updates that slot's tracker (last sequence,
// time of the last sequence change, count of timed-out scans) and collects an
// online bit per node. A record with end_of_scan set closes the scan: one
// output transaction carries the collected map with the own node bit set, and
// the collection starts over empty.
// Both data channels use valid/stall; the configuration channel uses
// valid/ready and is always ready. The user must write configuration only
// while idle; the block itself does not enforce it. Throughput is one record
// per cycle unless the receiver stalls. Stage one reads the slot store and
// compares sequence and time, stage two makes the timeout decision, updates
// the miss count and writes the store back, and the output register holds it.
// Back-to-back records for the same slot are forwarded around the store.
// Reset clears the configuration to its defaults, marks every slot as never
// written, clears the collected map and empties the pipeline.
// When the receiver stalls with a map waiting, the whole pipeline holds and
// in_stall_o rises; nothing is dropped or repeated.
`default_nettype none

module heartbeat_liveness_tracker_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Record channel.
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [hlt_pkg::SLOT_W-1:0]           slot_i,
  input  wire logic [hlt_pkg::MAGIC_W-1:0]          record_magic_i,
  input  wire logic [hlt_pkg::NODE_W-1:0]           record_node_i,
  input  wire logic [hlt_pkg::STATUS_W-1:0]         record_status_i,
  input  wire logic [hlt_pkg::SEQ_W-1:0]            record_sequence_i,
  input  wire logic [hlt_pkg::TIME_W-1:0]           scan_time_i,
  input  wire logic                                 end_of_scan_i,
  // Map channel.
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [hlt_pkg::MAP_W-1:0]                 alive_map_o,
  // Configuration write channel.
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [hlt_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [hlt_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  // Configuration registers.
  logic [hlt_pkg::MAGIC_W-1:0]  magic_q;
  logic [hlt_pkg::STATUS_W-1:0] online_q;
  logic [hlt_pkg::SLOT_W-1:0]   self_q;
  logic [hlt_pkg::TIME_W-1:0]   timeout_q;
  logic [hlt_pkg::MISS_W-1:0]   limit_q;

  // The pipeline advances whenever the output register is empty or is being
  // taken in this cycle; otherwise every stage holds.
  logic en;
  logic out_valid_q;
  logic [hlt_pkg::MAP_W-1:0] out_map_q;

  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign alive_map_o = out_map_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      online_q  <= hlt_pkg::ONLINE_RST;
      self_q    <= '0;
      timeout_q <= hlt_pkg::TIMEOUT_RST;
      limit_q   <= hlt_pkg::MISS_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hlt_pkg::CFG_MAGIC:      magic_q   <= cfg_data_i[hlt_pkg::MAGIC_W-1:0];
        hlt_pkg::CFG_ONLINE:     online_q  <= cfg_data_i[hlt_pkg::STATUS_W-1:0];
        hlt_pkg::CFG_SELF:       self_q    <= cfg_data_i[hlt_pkg::SLOT_W-1:0];
        hlt_pkg::CFG_TIMEOUT:    timeout_q <= cfg_data_i[hlt_pkg::TIME_W-1:0];
        hlt_pkg::CFG_MISS_LIMIT: limit_q   <= cfg_data_i[hlt_pkg::MISS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Slot store: one entry per node, registered read, write from stage two.
  // Entries that were never written read as all zero through valid flags.
  // ---------------------------------------------------------------------
  hlt_pkg::entry_t slot_mem [hlt_pkg::NODE_COUNT];
  logic [hlt_pkg::NODE_COUNT-1:0] ent_vld_q;
  hlt_pkg::entry_t rd_entry_q;
  logic            rd_vld_q;
  logic [hlt_pkg::IDX_W-1:0] rd_idx;

  logic            wr_en;
  logic [hlt_pkg::IDX_W-1:0] wr_idx;
  hlt_pkg::entry_t wr_entry;

  assign rd_idx = slot_i[hlt_pkg::IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_entry_q <= slot_mem[rd_idx];
    end
    if (wr_en) begin
      slot_mem[wr_idx] <= wr_entry;
    end
  end

  // ---------------------------------------------------------------------
  // Stage one: captured record plus the store read.
  // ---------------------------------------------------------------------
  logic                          s1_valid_q;
  logic [hlt_pkg::SLOT_W-1:0]    s1_slot_q;
  logic [hlt_pkg::MAGIC_W-1:0]   s1_magic_q;
  logic [hlt_pkg::NODE_W-1:0]    s1_node_q;
  logic [hlt_pkg::STATUS_W-1:0]  s1_status_q;
  logic [hlt_pkg::SEQ_W-1:0]     s1_seq_q;
  logic [hlt_pkg::TIME_W-1:0]    s1_now_q;
  logic                          s1_eos_q;

  // Last write into the store, which the stage one read did not yet see.
  logic                          lw_valid_q;
  logic [hlt_pkg::SLOT_W-1:0]    lw_slot_q;
  hlt_pkg::entry_t               lw_entry_q;

  // Stage two registers.
  logic                          s2_valid_q;
  logic [hlt_pkg::SLOT_W-1:0]    s2_slot_q;
  logic                          s2_wr_q;
  logic                          s2_ok_q;
  logic                          s2_refresh_q;
  logic [hlt_pkg::TIME_W-1:0]    s2_elapsed_q;
  logic [hlt_pkg::SEQ_W-1:0]     s2_seq_q;
  logic [hlt_pkg::TIME_W-1:0]    s2_time_q;
  logic [hlt_pkg::MISS_W-1:0]    s2_miss_q;
  logic                          s2_eos_q;

  logic [hlt_pkg::MISS_W-1:0]    s2_miss_new;
  logic                          s2_alive;

  // Current view of the slot for the record in stage one. A record one stage
  // ahead on the same slot wins, then the write of the cycle before, then the
  // store itself.
  hlt_pkg::entry_t s1_cur;
  logic            s1_in_range;
  logic            s1_ok;
  logic            s1_refresh;
  logic [hlt_pkg::TIME_W-1:0] s1_elapsed;

  always_comb begin
    if (s2_valid_q && s2_wr_q && (s2_slot_q == s1_slot_q)) begin
      s1_cur.seq      = s2_seq_q;
      s1_cur.chg_time = s2_time_q;
      s1_cur.miss     = s2_miss_new;
    end else if (lw_valid_q && (lw_slot_q == s1_slot_q)) begin
      s1_cur = lw_entry_q;
    end else if (rd_vld_q) begin
      s1_cur = rd_entry_q;
    end else begin
      s1_cur = '0;
    end
  end

  assign s1_in_range = ({1'b0, s1_slot_q} < (hlt_pkg::SLOT_W+1)'(hlt_pkg::NODE_COUNT));
  assign s1_ok       = (s1_magic_q == magic_q)
                    && (s1_node_q == hlt_pkg::NODE_W'(s1_slot_q))
                    && (s1_status_q == online_q);
  // A change time of zero means the slot was never seen.
  assign s1_refresh  = (s1_seq_q != s1_cur.seq) || (s1_cur.chg_time == '0);
  assign s1_elapsed  = s1_now_q - s1_cur.chg_time;

  // ---------------------------------------------------------------------
  // Stage two: timeout decision and miss count, then write back.
  // ---------------------------------------------------------------------
  always_comb begin
    if (!s2_ok_q) begin
      // Invalid or offline record only clears the miss count.
      s2_miss_new = '0;
      s2_alive    = 1'b0;
    end else if (s2_refresh_q) begin
      s2_miss_new = '0;
      s2_alive    = 1'b1;
    end else if (s2_elapsed_q < timeout_q) begin
      s2_miss_new = s2_miss_q;
      s2_alive    = 1'b1;
    end else begin
      s2_miss_new = (s2_miss_q == hlt_pkg::MISS_MAX) ? s2_miss_q
                                                     : s2_miss_q + 8'd1;
      s2_alive    = (s2_miss_new < limit_q);
    end
  end

  assign wr_en             = en && s2_valid_q && s2_wr_q;
  assign wr_idx            = s2_slot_q[hlt_pkg::IDX_W-1:0];
  assign wr_entry.seq      = s2_seq_q;
  assign wr_entry.chg_time = s2_time_q;
  assign wr_entry.miss     = s2_miss_new;

  logic [hlt_pkg::MAP_W-1:0] map_accum_q;
  logic [hlt_pkg::MAP_W-1:0] node_bit;
  logic [hlt_pkg::MAP_W-1:0] self_bit;
  logic [hlt_pkg::MAP_W-1:0] map_next;

  assign node_bit = (s2_wr_q && s2_alive) ? (hlt_pkg::MAP_W'(1) << s2_slot_q) : '0;
  assign self_bit = ({1'b0, self_q} < (hlt_pkg::SLOT_W+1)'(hlt_pkg::NODE_COUNT))
                  ? (hlt_pkg::MAP_W'(1) << self_q) : '0;
  assign map_next = map_accum_q | node_bit;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      lw_valid_q  <= 1'b0;
      rd_vld_q    <= 1'b0;
      ent_vld_q   <= '0;
      out_valid_q <= 1'b0;
      map_accum_q <= '0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      lw_valid_q <= s2_valid_q && s2_wr_q;
      rd_vld_q   <= ent_vld_q[rd_idx];
      if (wr_en) begin
        ent_vld_q[wr_idx] <= 1'b1;
      end
      out_valid_q <= s2_valid_q && s2_eos_q;
      if (s2_valid_q) begin
        map_accum_q <= s2_eos_q ? '0 : map_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_slot_q   <= slot_i;
      s1_magic_q  <= record_magic_i;
      s1_node_q   <= record_node_i;
      s1_status_q <= record_status_i;
      s1_seq_q    <= record_sequence_i;
      s1_now_q    <= scan_time_i;
      s1_eos_q    <= end_of_scan_i;

      lw_slot_q  <= s2_slot_q;
      lw_entry_q <= wr_entry;

      s2_slot_q    <= s1_slot_q;
      s2_wr_q      <= s1_in_range;
      s2_ok_q      <= s1_ok;
      s2_refresh_q <= s1_refresh;
      s2_elapsed_q <= s1_elapsed;
      s2_seq_q     <= (s1_ok && s1_refresh) ? s1_seq_q : s1_cur.seq;
      s2_time_q    <= (s1_ok && s1_refresh) ? s1_now_q : s1_cur.chg_time;
      s2_miss_q    <= s1_cur.miss;
      s2_eos_q     <= s1_eos_q;

      if (s2_valid_q && s2_eos_q) begin
        out_map_q <= map_next | self_bit;
      end
    end
  end

endmodule

`default_nettype wire

// ----- test/heartbeat_liveness_tracker_unit_tb.sv -----
module heartbeat_liveness_tracker_unit_tb;
  import hlt_pkg::*;

  // Cycles allowed for records that are still in the pipeline but cause no map.
  // A record passes stage one, stage two and the output register, so this leaves margin.
  localparam int unsigned SETTLE_CYCLES = 6;
  // Length of the long receiver hold-off that fills the pipeline.
  localparam int unsigned HOLD_CYCLES   = 150;
  // Number of records that are offered back to back while the receiver holds off.
  localparam int unsigned HOLD_RECORDS  = 40;
  localparam int unsigned DIR_ROWS      = 20;
  // Upper bound on the final drain, in cycles.
  localparam int unsigned DRAIN_LIMIT   = 20000;

  // One heartbeat record as it goes into the block.
  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [MAGIC_W-1:0]  magic;
    logic [NODE_W-1:0]   node;
    logic [STATUS_W-1:0] status;
    logic [SEQ_W-1:0]    seq_num;
    logic [TIME_W-1:0]   scan_ns;
    logic                eos;
  } heartbeat_t;

  // One row of the directed table. When has_map is set, the map of that row is
  // typed in by hand; otherwise the tracker model below supplies it.
  typedef struct packed {
    heartbeat_t       rec;
    logic             has_map;
    logic [MAP_W-1:0] map;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  heartbeat_t            rec_drv;
  logic                  out_valid;
  logic                  out_stall;
  logic [MAP_W-1:0]      alive_map;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  heartbeat_liveness_tracker_unit uut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .slot_i            (rec_drv.slot),
    .record_magic_i    (rec_drv.magic),
    .record_node_i     (rec_drv.node),
    .record_status_i   (rec_drv.status),
    .record_sequence_i (rec_drv.seq_num),
    .scan_time_i       (rec_drv.scan_ns),
    .end_of_scan_i     (rec_drv.eos),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .alive_map_o       (alive_map),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  // Tracker model: a private copy of the configuration and the per-slot state.
  logic [MAGIC_W-1:0]  magic_cfg;
  logic [STATUS_W-1:0] online_cfg;
  logic [SLOT_W-1:0]   self_cfg;
  logic [TIME_W-1:0]   timeout_cfg;
  logic [MISS_W-1:0]   limit_cfg;

  logic [SEQ_W-1:0]    last_seq   [NODE_COUNT];
  logic [TIME_W-1:0]   changed_at [NODE_COUNT];
  logic [MISS_W-1:0]   misses     [NODE_COUNT];
  logic [MAP_W-1:0]    scan_map;

  // Maps still owed by the block, oldest first.
  logic [MAP_W-1:0]    pending_maps [$];
  logic [MAP_W-1:0]    map_due;

  // Sequence numbers that the stimulus currently writes for each slot.
  logic [SEQ_W-1:0]    stim_seq [NODE_COUNT];

  dir_row_t            dir_tab [DIR_ROWS];

  int                  errors;
  bit                  quiet;
  bit                  hold_req;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void init_tracker();
    magic_cfg   = '0;
    online_cfg  = ONLINE_RST;
    self_cfg    = '0;
    timeout_cfg = TIMEOUT_RST;
    limit_cfg   = MISS_LIMIT_RST;
    for (int i = 0; i < NODE_COUNT; i++) begin
      last_seq[i]   = '0;
      changed_at[i] = '0;
      misses[i]     = '0;
      stim_seq[i]   = '0;
    end
    scan_map = '0;
  endfunction

  function automatic void apply_config(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_MAGIC:      magic_cfg   = data[MAGIC_W-1:0];
      CFG_ONLINE:     online_cfg  = data[STATUS_W-1:0];
      CFG_SELF:       self_cfg    = data[SLOT_W-1:0];
      CFG_TIMEOUT:    timeout_cfg = data[TIME_W-1:0];
      CFG_MISS_LIMIT: limit_cfg   = data[MISS_W-1:0];
      default: ;
    endcase
  endfunction

  // Applies one record to the tracker copy. Returns 1 when the record closes a
  // scan, with the map that the block must then emit. The slot field is six bits
  // wide and the store has 64 entries, so every slot is in range here.
  function automatic bit track_record(heartbeat_t r, output logic [MAP_W-1:0] map);
    bit               alive;
    logic [TIME_W-1:0] elapsed;
    alive = 1'b0;
    if (r.magic != magic_cfg || r.node != NODE_W'(r.slot) || r.status != online_cfg) begin
      // A broken or offline record only clears the run of misses.
      misses[r.slot] = '0;
    end else if (r.seq_num != last_seq[r.slot] || changed_at[r.slot] == '0) begin
      // Fresh heartbeat, or a slot that counts as never seen: restart tracking.
      last_seq[r.slot]   = r.seq_num;
      changed_at[r.slot] = r.scan_ns;
      misses[r.slot]     = '0;
      alive = 1'b1;
    end else begin
      // The difference wraps, so a clock that went back looks like a long wait.
      elapsed = r.scan_ns - changed_at[r.slot];
      if (elapsed < timeout_cfg) begin
        alive = 1'b1;
      end else begin
        if (misses[r.slot] != MISS_MAX) begin
          misses[r.slot] = misses[r.slot] + 1'b1;
        end
        alive = misses[r.slot] < limit_cfg;
      end
    end
    if (alive) begin
      scan_map[r.slot] = 1'b1;
    end
    map = scan_map | (MAP_W'(1) << self_cfg);
    if (r.eos) begin
      scan_map = '0;
    end
    return r.eos;
  endfunction

  function automatic dir_row_t row(logic [SLOT_W-1:0] slot, logic [MAGIC_W-1:0] magic,
                                   logic [NODE_W-1:0] node, logic [STATUS_W-1:0] status,
                                   logic [SEQ_W-1:0] seq_num, logic [TIME_W-1:0] scan_ns,
                                   logic eos, logic has_map, logic [MAP_W-1:0] map);
    dir_row_t d;
    d.rec.slot    = slot;
    d.rec.magic   = magic;
    d.rec.node    = node;
    d.rec.status  = status;
    d.rec.seq_num = seq_num;
    d.rec.scan_ns = scan_ns;
    d.rec.eos     = eos;
    d.has_map     = has_map;
    d.map         = map;
    return d;
  endfunction

  // Most gaps are short; a few are long. In a quiet stretch there are none.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Offers one record and holds it until the block takes the transaction. The
  // task starts and ends at a falling edge. Valid stays high when the gap is zero,
  // so the caller must drive the next record, or drop valid, at once.
  task automatic send_record(heartbeat_t r, bit typed, logic [MAP_W-1:0] typed_map, int gap);
    logic [MAP_W-1:0] map;
    in_valid = 1'b1;
    rec_drv  = r;
    do begin
      @(posedge clk);
    end while (in_stall);
    if (track_record(r, map)) begin
      pending_maps.push_back(typed ? typed_map : map);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Waits until every owed map has come out and the pipeline has run dry.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_maps.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    apply_config(idx, data);
    @(negedge clk);
  endtask

  // Registers are only rewritten once the block is idle.
  task automatic set_config(logic [MAGIC_W-1:0] magic, logic [STATUS_W-1:0] online,
                            logic [SLOT_W-1:0] self_idx, logic [TIME_W-1:0] timeout,
                            logic [MISS_W-1:0] limit);
    wait_idle();
    write_reg(CFG_MAGIC, CFG_DATA_W'(magic));
    write_reg(CFG_ONLINE, CFG_DATA_W'(online));
    write_reg(CFG_SELF, CFG_DATA_W'(self_idx));
    write_reg(CFG_TIMEOUT, timeout);
    write_reg(CFG_MISS_LIMIT, CFG_DATA_W'(limit));
    cfg_valid = 1'b0;
  endtask

  // Random scans. Most records are well formed heartbeats from a small pool of
  // slots so that sequences repeat and time-outs build up; the rest are broken
  // records. The scan clock advances between scans and now and then steps back.
  // With hold set, the receiver holds off in the middle of the phase while a burst
  // of end-of-scan records keeps coming, which backs the pipeline up.
  task automatic run_phase(int items, int pool, int noise_pct, int chg_pct, int step_max,
                           bit calm, bit hold);
    logic [SLOT_W-1:0] slots [8];
    logic [TIME_W-1:0] now;
    heartbeat_t        r;
    int                left;
    bit                burst;
    quiet = calm;
    for (int k = 0; k < 8; k++) begin
      slots[k] = SLOT_W'($urandom_range(0, NODE_COUNT - 1));
    end
    if ($urandom_range(0, 3) == 0) begin
      now = {$urandom, $urandom};
    end else begin
      now = TIME_W'($urandom_range(1, 1000));
    end
    left = $urandom_range(1, 8);
    for (int i = 0; i < items; i++) begin
      burst = hold && i >= items / 2 && i < items / 2 + HOLD_RECORDS;
      if (hold && i == items / 2) begin
        hold_req = 1'b1;
      end
      r.slot = slots[$urandom_range(0, pool - 1)];
      if ($urandom_range(0, 99) < chg_pct) begin
        if ($urandom_range(0, 1) == 0) begin
          stim_seq[r.slot] = stim_seq[r.slot] + 1'b1;
        end else begin
          stim_seq[r.slot] = {$urandom, $urandom};
        end
      end
      r.magic   = magic_cfg;
      r.node    = NODE_W'(r.slot);
      r.status  = online_cfg;
      r.seq_num = stim_seq[r.slot];
      r.scan_ns = now;
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 3))
          0: r.magic = $urandom;
          1: r.node = $urandom;
          2: r.status = STATUS_W'($urandom_range(0, 255));
          default: begin
            r.slot    = SLOT_W'($urandom_range(0, NODE_COUNT - 1));
            r.magic   = $urandom;
            r.node    = $urandom;
            r.status  = STATUS_W'($urandom_range(0, 255));
            r.seq_num = {$urandom, $urandom};
            r.scan_ns = {$urandom, $urandom};
          end
        endcase
      end
      left--;
      r.eos = left == 0 || burst;
      send_record(r, 1'b0, '0, burst ? 0 : pick_gap());
      if (left == 0) begin
        left = $urandom_range(1, 8);
        now  = now + TIME_W'($urandom_range(0, step_max));
        if ($urandom_range(0, 99) < 3) begin
          now = now - TIME_W'($urandom_range(1, step_max + 1));
        end
      end
    end
  endtask

  // Receiver: random stalls, mostly short, a few long, none in quiet stretches,
  // and one long hold-off on request that is counted out here.
  initial begin : map_receiver
    int r;
    int len;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        hold_req  = 1'b0;
      end else if (quiet) begin
        out_stall = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_stall = 1'b0;
        end else begin
          out_stall = 1'b1;
          len = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
          repeat (len - 1) @(negedge clk);
        end
      end
    end
  end

  // Every map transaction is checked against the oldest owed map.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_maps.size() == 0) begin
        $error("alive_map: no map expected, actual %h", alive_map);
        errors++;
      end else begin
        map_due = pending_maps.pop_front();
        if (alive_map !== map_due) begin
          $error("alive_map: expected %h, actual %h", map_due, alive_map);
          errors++;
        end
      end
    end
  end

  // Directed table under the reset configuration: magic 0, online code 1, own
  // node 0, a timeout of five seconds and a miss limit of three.
  initial begin
    dir_tab[0]  = row(6'd5, 32'd0, 32'd5, 8'd1, 64'd10, 64'd100, 1'b1, 1'b1, 64'h21);
    // Same sequence inside the timeout keeps the node online.
    dir_tab[1]  = row(6'd5, 32'd0, 32'd5, 8'd1, 64'd10, 64'd200, 1'b1, 1'b1, 64'h21);
    // Past the timeout, misses count up until the limit takes the node offline.
    dir_tab[2]  = row(6'd5, 32'd0, 32'd5, 8'd1, 64'd10, 64'd100 + TIMEOUT_RST, 1'b1, 1'b0, '0);
    dir_tab[3]  = row(6'd5, 32'd0, 32'd5, 8'd1, 64'd10, 64'd101 + TIMEOUT_RST, 1'b1, 1'b0, '0);
    dir_tab[4]  = row(6'd5, 32'd0, 32'd5, 8'd1, 64'd10, 64'd102 + TIMEOUT_RST, 1'b1, 1'b1, 64'h1);
    // A bad magic clears the misses, so the next timed-out scan is online again.
    dir_tab[5]  = row(6'd5, 32'd1, 32'd5, 8'd1, 64'd10, 64'd103 + TIMEOUT_RST, 1'b0, 1'b0, '0);
    dir_tab[6]  = row(6'd5, 32'd0, 32'd5, 8'd1, 64'd10, 64'd100 + 2 * TIMEOUT_RST, 1'b1,
                      1'b0, '0);
    // A refresh at time zero leaves the slot looking never seen.
    dir_tab[7]  = row(6'd7, 32'd0, 32'd7, 8'd1, 64'd0, 64'd0, 1'b0, 1'b0, '0);
    dir_tab[8]  = row(6'd7, 32'd0, 32'd7, 8'd1, 64'd0, 64'd1000000000000, 1'b1, 1'b0, '0);
    // Scan time going back reads as a very long wait.
    dir_tab[9]  = row(6'd9, 32'd0, 32'd9, 8'd1, 64'd3, 64'd1000, 1'b0, 1'b0, '0);
    dir_tab[10] = row(6'd9, 32'd0, 32'd9, 8'd1, 64'd3, 64'd500, 1'b1, 1'b0, '0);
    // Wrong node id, offline status and an extreme status: only the own bit is left.
    dir_tab[11] = row(6'd10, 32'd0, 32'hFFFF_FFFF, 8'd1, 64'd1, 64'd1, 1'b0, 1'b0, '0);
    dir_tab[12] = row(6'd11, 32'd0, 32'd11, 8'd0, 64'd1, 64'd1, 1'b0, 1'b0, '0);
    dir_tab[13] = row(6'd12, 32'd0, 32'd12, 8'hFF, 64'd1, 64'd1, 1'b1, 1'b1, 64'h1);
    // Top slot with all-ones sequence and time.
    dir_tab[14] = row(6'd63, 32'd0, 32'd63, 8'd1, '1, '1, 1'b1, 1'b1, 64'h8000_0000_0000_0001);
    // The same slot twice within one scan, and a broken record for the own slot.
    dir_tab[15] = row(6'd0, 32'd0, 32'd0, 8'd1, 64'd5, 64'd7, 1'b0, 1'b0, '0);
    dir_tab[16] = row(6'd20, 32'd0, 32'd20, 8'd1, 64'd1, 64'd50, 1'b0, 1'b0, '0);
    dir_tab[17] = row(6'd20, 32'd0, 32'd20, 8'd1, 64'd2, 64'd60, 1'b0, 1'b0, '0);
    dir_tab[18] = row(6'd0, 32'hFFFF_FFFF, 32'd0, 8'd1, 64'd5, 64'd70, 1'b1, 1'b0, '0);
    dir_tab[19] = row(6'd62, 32'd0, 32'h8000_003E, 8'd1, 64'd9, 64'd80, 1'b1, 1'b1, 64'h1);
  end

  // Main sequence: reset, directed table, then phases with fresh register values.
  initial begin
    errors    = 0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    rec_drv   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAGIC;
    cfg_data  = '0;
    init_tracker();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_record(dir_tab[i].rec, dir_tab[i].has_map, dir_tab[i].map, pick_gap());
    end

    // Upper extremes of every register, with the long hold-off in the middle.
    set_config('1, '1, '1, '1, '1);
    run_phase(150, 8, 20, 30, 2000, 1'b0, 1'b1);

    // Random registers with short timeouts so that misses build up; one phase
    // without idling and one with a timeout of random magnitude.
    for (int p = 0; p < 4; p++) begin
      set_config($urandom, STATUS_W'($urandom_range(0, 255)),
                 SLOT_W'($urandom_range(0, NODE_COUNT - 1)),
                 (p == 3) ? {$urandom, $urandom} : 64'($urandom_range(0, 4000)),
                 MISS_W'($urandom_range(1, 6)));
      run_phase(120, 8, 20, 25, 1500, p == 1, 1'b0);
    end

    // A miss limit of zero takes a timed-out node offline at once.
    set_config($urandom, STATUS_W'($urandom_range(0, 255)),
               SLOT_W'($urandom_range(0, NODE_COUNT - 1)),
               TIME_W'($urandom_range(0, 3000)), '0);
    run_phase(120, 6, 15, 20, 1500, 1'b0, 1'b0);

    // One slot with a frozen sequence and no timeout drives the miss count into
    // saturation.
    set_config($urandom, STATUS_W'($urandom_range(0, 255)),
               SLOT_W'($urandom_range(0, NODE_COUNT - 1)), '0, '1);
    run_phase(300, 1, 0, 0, 100, 1'b0, 1'b0);

    // Lower extremes, but a miss limit of one.
    set_config('0, '0, '0, '0, 8'd1);
    run_phase(100, 8, 20, 30, 500, 1'b0, 1'b0);

    // Drain with a bound, then let the pipeline settle.
    in_valid = 1'b0;
    quiet    = 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && pending_maps.size() != 0; n++) begin
      @(negedge clk);
    end
    if (pending_maps.size() != 0) begin
      $error("alive_map: %0d maps never arrived", pending_maps.size());
      errors++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for a run that hangs.
  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule
